// ===== rtl/scq_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo quadrature chorus package
// Shared widths, register indexes, reset values, sequencer states and the
// quarter-wave sine generator used to build the lane tables.
// ----------------------------------------------------------------------------
package scq_pkg;

    localparam int DELAY_DEPTH_DEF  = 2048;
    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int SINE_ENTRIES_DEF = 1024;

    localparam int DEPTH_W     = 19;
    localparam int PERIOD_W    = 24;
    localparam int STEP_W      = 25;
    localparam int WET_W       = 16;
    localparam int THETA_W     = 24;
    localparam int FRAC_W      = 24;
    localparam int LFO_W       = 16;
    localparam int SINE_W      = 15;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 25;

    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_LEFT  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_RIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LFO_PERIOD  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LFO_STEP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WET_MIX     = 3'd4;

    localparam logic [DEPTH_W-1:0]  DEPTH_RST  = 19'd122880;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 24'd48000;
    localparam logic [STEP_W-1:0]   STEP_RST   = 25'd350;
    localparam logic [WET_W-1:0]    WET_RST    = 16'd16384;

    // Unity gain in Q1.15, also the midpoint of the unipolar LFO.
    localparam logic [WET_W-1:0]   WET_ONE      = 16'd32768;
    localparam logic [LFO_W-1:0]   LFO_MID      = 16'd32768;
    localparam logic [THETA_W-1:0] QUARTER_TURN = 24'h400000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_THETA,
        ST_SINE,
        ST_PROD,
        ST_ADDR,
        ST_RDA,
        ST_RDB,
        ST_INTERP,
        ST_DELAYED,
        ST_MIX,
        ST_SUM
    } scq_state_t;

    typedef struct packed {
        scq_state_t           state;
        logic                 advance;
        logic [THETA_W-1:0]   theta;
    } scq_ctrl_t;

    // Sine magnitude in Q0.15 for a first-quadrant angle r in Q0.30 of a
    // quarter turn. Taylor series in Q30, rounded half up. Elaboration only.
    function automatic logic [SINE_W-1:0] sine_mag(input logic [63:0] r);
        logic [63:0] q30_one;
        logic [63:0] half_pi;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        q30_one = 64'd1073741824;
        half_pi = 64'd1686629713;
        x  = (r * half_pi) >> 30;
        x2 = (x * x) >> 30;
        t  = q30_one;
        t  = q30_one - ((x2 * t) >> 30) / 64'd110;
        t  = q30_one - ((x2 * t) >> 30) / 64'd72;
        t  = q30_one - ((x2 * t) >> 30) / 64'd42;
        t  = q30_one - ((x2 * t) >> 30) / 64'd20;
        t  = q30_one - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[SINE_W-1:0];
    endfunction

endpackage

// ===== rtl/scq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module scq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/scq_lane.sv =====
// ----------------------------------------------------------------------------
// Chorus lane
// One audio channel: LFO sine lookup, modulated delay, interpolated read from
// the channel's delay line, and the wet/dry mix with saturation.
// ----------------------------------------------------------------------------
module scq_lane #(
    parameter int DELAY_DEPTH  = scq_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS  = scq_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_ENTRIES = scq_pkg::SINE_ENTRIES_DEF
) (
    input  logic                                aclk,
    input  scq_pkg::scq_ctrl_t                  ctrl,
    input  logic [scq_pkg::DEPTH_W-1:0]         depth,
    input  logic [scq_pkg::WET_W-1:0]           wet,
    input  logic [scq_pkg::WET_W-1:0]           dry,
    input  logic [SAMPLE_BITS-1:0]              sample,
    input  logic [$clog2(DELAY_DEPTH)-1:0]      wr_pos,
    input  logic [$clog2(DELAY_DEPTH+1)-1:0]    fill,
    output logic [SAMPLE_BITS-1:0]              result
);

    localparam int ADDR_W  = $clog2(DELAY_DEPTH);
    localparam int FILL_W  = $clog2(DELAY_DEPTH + 1);
    localparam int IDX_W   = $clog2(SINE_ENTRIES);
    localparam int QTR     = SINE_ENTRIES / 4;
    localparam int QIDX_W  = IDX_W - 1;
    localparam int FRAC_W  = scq_pkg::FRAC_W;
    localparam int PROD_W  = scq_pkg::DEPTH_W + scq_pkg::LFO_W;
    localparam int CMP_W   = (ADDR_W + FRAC_W > PROD_W + 1) ? ADDR_W + FRAC_W : PROD_W + 1;
    localparam int DIFF_W  = SAMPLE_BITS + 1;
    localparam int IP_W    = DIFF_W + FRAC_W + 1;
    localparam int MP_W    = SAMPLE_BITS + scq_pkg::WET_W + 1;
    localparam int SUM_W   = MP_W + 1;

    localparam logic [CMP_W-1:0]        DELAY_CAP  = CMP_W'(DELAY_DEPTH - 1) << FRAC_W;
    localparam logic [CMP_W-1:0]        DELAY_BASE = CMP_W'(2) << FRAC_W;
    localparam logic [ADDR_W-1:0]       ADDR_LAST  = ADDR_W'(DELAY_DEPTH - 1);
    localparam logic [ADDR_W-1:0]       ADDR_WRAP  = ADDR_W'(DELAY_DEPTH);
    localparam logic signed [IP_W-1:0]  IP_HALF    = IP_W'(1) << (FRAC_W - 1);
    localparam logic signed [SUM_W-1:0] MIX_HALF   = SUM_W'(1) << 14;
    localparam logic signed [SUM_W-1:0] SAT_HI     = (SUM_W'(1) << (SAMPLE_BITS - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO     = -SAT_HI - SUM_W'(1);

    // Quarter-wave table; the odd quadrants read it backward.
    logic [scq_pkg::SINE_W-1:0] sine_rom [QTR + 1];

    for (genvar g = 0; g <= QTR; g++) begin : g_rom
        localparam logic [63:0] ROM_ARG = (64'(g) << 30) / QTR;
        assign sine_rom[g] = scq_pkg::sine_mag(ROM_ARG);
    end

    logic [scq_pkg::LFO_W-1:0]  lfo_reg, lfo_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic [ADDR_W-1:0]          addr_a_reg, addr_a_next;
    logic [ADDR_W-1:0]          addr_b_reg, addr_b_next;
    logic [FRAC_W-1:0]          frac_reg, frac_next;
    logic signed [MP_W-1:0]     dry_prod_reg, dry_prod_next;
    logic [SAMPLE_BITS-1:0]     a_reg, a_next;
    logic signed [IP_W-1:0]     ip_reg, ip_next;
    logic [SAMPLE_BITS-1:0]     delayed_reg, delayed_next;
    logic signed [MP_W-1:0]     wet_prod_reg, wet_prod_next;

    logic [IDX_W-1:0]           sine_idx;
    logic [1:0]                 quad;
    logic [QIDX_W-1:0]          quarter_pos;
    logic [QIDX_W-1:0]          rom_addr;
    logic [scq_pkg::SINE_W-1:0] mag;
    logic [scq_pkg::LFO_W-1:0]  lfo_val;
    logic [CMP_W-1:0]           delay_full;
    logic [ADDR_W-1:0]          whole;
    logic [FRAC_W-1:0]          frac;
    logic [ADDR_W:0]            back;
    logic [ADDR_W-1:0]          addr_a;
    logic [ADDR_W-1:0]          addr_b;
    logic [ADDR_W-1:0]          rd_addr;
    logic [SAMPLE_BITS-1:0]     rd_data;
    logic                       a_valid;
    logic                       b_valid;
    logic [SAMPLE_BITS-1:0]     b_word;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [FRAC_W:0]     frac_s;
    logic signed [IP_W-1:0]     ip_sum;
    logic signed [IP_W-1:0]     ip_shift;
    logic signed [DIFF_W-1:0]   delayed;
    logic signed [scq_pkg::WET_W:0] wet_s;
    logic signed [scq_pkg::WET_W:0] dry_s;
    logic signed [SUM_W-1:0]    mix_sum;
    logic signed [SUM_W-1:0]    mix_shift;

    // LFO lookup.
    assign sine_idx    = ctrl.theta[scq_pkg::THETA_W-1 -: IDX_W];
    assign quad        = sine_idx[IDX_W-1 -: 2];
    assign quarter_pos = {1'b0, sine_idx[IDX_W-3:0]};
    assign rom_addr    = quad[0] ? (QIDX_W'(QTR) - quarter_pos) : quarter_pos;
    assign mag         = sine_rom[rom_addr];
    assign lfo_val     = quad[1] ? (scq_pkg::LFO_MID - {1'b0, mag})
                                 : (scq_pkg::LFO_MID + {1'b0, mag});

    // Delay in 1/2^24 samples, clamped to the oldest entry of the line.
    assign delay_full = CMP_W'(prod_reg) + DELAY_BASE;

    always_comb begin
        if (delay_full > DELAY_CAP) begin
            whole = ADDR_LAST;
            frac  = '0;
        end else begin
            whole = delay_full[FRAC_W +: ADDR_W];
            frac  = delay_full[FRAC_W-1:0];
        end
    end

    assign back   = {1'b0, wr_pos} - {1'b0, whole};
    assign addr_a = back[ADDR_W] ? (back[ADDR_W-1:0] + ADDR_WRAP) : back[ADDR_W-1:0];
    assign addr_b = (addr_a == '0) ? ADDR_LAST : (addr_a - ADDR_W'(1));

    // The line is written in address order from reset, so every address below
    // the fill count holds a sample and the rest still read as silence.
    assign a_valid = FILL_W'(addr_a_reg) < fill;
    assign b_valid = FILL_W'(addr_b_reg) < fill;
    assign b_word  = b_valid ? rd_data : '0;

    assign rd_addr = (ctrl.state == scq_pkg::ST_RDA) ? addr_a_reg : addr_b_reg;

    assign diff     = $signed({b_word[SAMPLE_BITS-1], b_word})
                    - $signed({a_reg[SAMPLE_BITS-1], a_reg});
    assign frac_s   = $signed({1'b0, frac_reg});
    assign ip_sum   = ip_reg + IP_HALF;
    assign ip_shift = ip_sum >>> FRAC_W;
    assign delayed  = $signed({a_reg[SAMPLE_BITS-1], a_reg}) + ip_shift[DIFF_W-1:0];

    assign wet_s = $signed({1'b0, wet});
    assign dry_s = $signed({1'b0, dry});

    assign mix_sum   = SUM_W'(wet_prod_reg) + SUM_W'(dry_prod_reg) + MIX_HALF;
    assign mix_shift = mix_sum >>> 15;

    always_comb begin
        if (mix_shift > SAT_HI) begin
            result = SAT_HI[SAMPLE_BITS-1:0];
        end else if (mix_shift < SAT_LO) begin
            result = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            result = mix_shift[SAMPLE_BITS-1:0];
        end
    end

    always_comb begin
        lfo_next      = lfo_reg;
        prod_next     = prod_reg;
        addr_a_next   = addr_a_reg;
        addr_b_next   = addr_b_reg;
        frac_next     = frac_reg;
        dry_prod_next = dry_prod_reg;
        a_next        = a_reg;
        ip_next       = ip_reg;
        delayed_next  = delayed_reg;
        wet_prod_next = wet_prod_reg;
        unique case (ctrl.state)
            scq_pkg::ST_SINE: begin
                lfo_next = lfo_val;
            end
            scq_pkg::ST_PROD: begin
                prod_next = PROD_W'(depth) * PROD_W'(lfo_reg);
            end
            scq_pkg::ST_ADDR: begin
                addr_a_next = addr_a;
                addr_b_next = addr_b;
                frac_next   = frac;
            end
            scq_pkg::ST_RDA: begin
                dry_prod_next = MP_W'(dry_s) * MP_W'($signed(sample));
            end
            scq_pkg::ST_RDB: begin
                a_next = a_valid ? rd_data : '0;
            end
            scq_pkg::ST_INTERP: begin
                ip_next = IP_W'(diff) * IP_W'(frac_s);
            end
            scq_pkg::ST_DELAYED: begin
                delayed_next = delayed[SAMPLE_BITS-1:0];
            end
            scq_pkg::ST_MIX: begin
                wet_prod_next = MP_W'(wet_s) * MP_W'($signed(delayed_reg));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        lfo_reg      <= lfo_next;
        prod_reg     <= prod_next;
        addr_a_reg   <= addr_a_next;
        addr_b_reg   <= addr_b_next;
        frac_reg     <= frac_next;
        dry_prod_reg <= dry_prod_next;
        a_reg        <= a_next;
        ip_reg       <= ip_next;
        delayed_reg  <= delayed_next;
        wet_prod_reg <= wet_prod_next;
    end

    scq_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DELAY_DEPTH)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (ctrl.advance),
        .wr_addr (wr_pos),
        .wr_data (sample),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ===== rtl/scq_seq.sv =====
// ----------------------------------------------------------------------------
// Chorus sequencer
// Steps both lanes through one request, and owns the LFO phase, the delay
// line write pointer and the fill count.
// ----------------------------------------------------------------------------
module scq_seq #(
    parameter int DELAY_DEPTH = scq_pkg::DELAY_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  logic                              out_free,
    input  logic [scq_pkg::PERIOD_W-1:0]      lfo_period,
    input  logic [scq_pkg::THETA_W-1:0]       lfo_step,
    output logic                              in_ready,
    output scq_pkg::scq_ctrl_t                ctrl,
    output logic [$clog2(DELAY_DEPTH)-1:0]    wr_pos,
    output logic [$clog2(DELAY_DEPTH+1)-1:0]  fill
);

    localparam int ADDR_W  = $clog2(DELAY_DEPTH);
    localparam int FILL_W  = $clog2(DELAY_DEPTH + 1);
    localparam int THETA_W = scq_pkg::THETA_W;
    localparam int PHASE_W = scq_pkg::PERIOD_W;

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DELAY_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DELAY_DEPTH);

    scq_pkg::scq_state_t     state_reg, state_next;
    logic [PHASE_W-1:0]      phase_reg, phase_next;
    logic [THETA_W-1:0]      theta_reg, theta_next;
    logic [ADDR_W-1:0]       wr_pos_reg, wr_pos_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;

    logic                    advance;
    logic [2*THETA_W-1:0]    theta_prod;
    logic [PHASE_W:0]        phase_inc;

    assign theta_prod = (2*THETA_W)'(phase_reg) * (2*THETA_W)'(lfo_step);
    assign phase_inc  = {1'b0, phase_reg} + (PHASE_W+1)'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= scq_pkg::ST_IDLE;
            phase_reg  <= '0;
            theta_reg  <= '0;
            wr_pos_reg <= '0;
            fill_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            theta_reg  <= theta_next;
            wr_pos_reg <= wr_pos_next;
            fill_reg   <= fill_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        theta_next  = theta_reg;
        wr_pos_next = wr_pos_reg;
        fill_next   = fill_reg;
        advance     = 1'b0;
        unique case (state_reg)
            scq_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = scq_pkg::ST_THETA;
                end
            end
            scq_pkg::ST_THETA: begin
                theta_next = theta_prod[THETA_W-1:0];
                state_next = scq_pkg::ST_SINE;
            end
            scq_pkg::ST_SINE:    state_next = scq_pkg::ST_PROD;
            scq_pkg::ST_PROD:    state_next = scq_pkg::ST_ADDR;
            scq_pkg::ST_ADDR:    state_next = scq_pkg::ST_RDA;
            scq_pkg::ST_RDA:     state_next = scq_pkg::ST_RDB;
            scq_pkg::ST_RDB:     state_next = scq_pkg::ST_INTERP;
            scq_pkg::ST_INTERP:  state_next = scq_pkg::ST_DELAYED;
            scq_pkg::ST_DELAYED: state_next = scq_pkg::ST_MIX;
            scq_pkg::ST_MIX:     state_next = scq_pkg::ST_SUM;
            scq_pkg::ST_SUM: begin
                // The request retires only when the output register can take it.
                if (out_free) begin
                    advance     = 1'b1;
                    state_next  = scq_pkg::ST_IDLE;
                    wr_pos_next = (wr_pos_reg == ADDR_LAST) ? '0 : wr_pos_reg + ADDR_W'(1);
                    if (fill_reg != FILL_FULL) begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    if (phase_inc > {1'b0, lfo_period}) begin
                        phase_next = '0;
                    end else begin
                        phase_next = phase_inc[PHASE_W-1:0];
                    end
                end
            end
            default: state_next = scq_pkg::ST_IDLE;
        endcase
    end

    assign in_ready      = (state_reg == scq_pkg::ST_IDLE);
    assign ctrl.state    = state_reg;
    assign ctrl.advance  = advance;
    assign ctrl.theta    = theta_reg;
    assign wr_pos        = wr_pos_reg;
    assign fill          = fill_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_FULL)
        else $error("delay line fill count beyond the line length");

    a_fill_tracks_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != FILL_FULL) |-> (FILL_W'(wr_pos_reg) == fill_reg))
        else $error("write pointer and fill count disagree before the line is full");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == scq_pkg::ST_IDLE) && !in_valid)
            |=> ($stable(wr_pos_reg) && $stable(phase_reg) && $stable(fill_reg)))
        else $error("pointer or phase moved without a completed request");

endmodule

// ===== rtl/stereo_quadrature_chorus_top.sv =====
// ----------------------------------------------------------------------------
// Stereo quadrature chorus
// Each request carries one stereo pair and yields one mixed stereo pair. A
// shared LFO phase drives a left lane on the sine and a right lane on the
// sine a quarter turn later; each lane reads a modulated, interpolated delay
// from its own delay line and blends it with the dry input.
//
// Input channel s_valid/s_ready with s_left_sample and s_right_sample; result
// channel m_valid/m_ready with m_left_out and m_right_out. Registers are set
// through cfg_wr_en/cfg_index/cfg_wdata while no request is in flight.
// A request is accepted only while the sequencer is idle. It then passes
// through the sequencer steps theta, sine, product, address, the two reads,
// interpolation, delayed sample, mix and sum; the result enters the output
// register as the sequencer returns to idle, so a new request waits until the
// last has retired. The steps are set by at most one multiplier per lane step
// and the two reads of the single read port of each delay line.
// Reset loads the register defaults and zeroes the phase, write pointer and
// fill count; delay line entries not yet written read as zero, so no clearing
// pass is run. When the receiver stalls, the result waits in the output
// register and the next request, once accepted, holds in its final step.
// ----------------------------------------------------------------------------
module stereo_quadrature_chorus_top #(
    parameter int DELAY_DEPTH  = scq_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS  = scq_pkg::SAMPLE_BITS_DEF,
    parameter int SINE_ENTRIES = scq_pkg::SINE_ENTRIES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [scq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [scq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [SAMPLE_BITS-1:0]             s_left_sample,
    input  logic [SAMPLE_BITS-1:0]             s_right_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [SAMPLE_BITS-1:0]             m_left_out,
    output logic [SAMPLE_BITS-1:0]             m_right_out
);

    localparam int ADDR_W = $clog2(DELAY_DEPTH);
    localparam int FILL_W = $clog2(DELAY_DEPTH + 1);
    localparam int WET_W  = scq_pkg::WET_W;

    logic [scq_pkg::DEPTH_W-1:0]  depth_left_reg, depth_left_next;
    logic [scq_pkg::DEPTH_W-1:0]  depth_right_reg, depth_right_next;
    logic [scq_pkg::PERIOD_W-1:0] lfo_period_reg, lfo_period_next;
    logic [scq_pkg::STEP_W-1:0]   lfo_step_reg, lfo_step_next;
    logic [WET_W-1:0]             wet_mix_reg, wet_mix_next;

    logic [SAMPLE_BITS-1:0]       in_left_reg, in_left_next;
    logic [SAMPLE_BITS-1:0]       in_right_reg, in_right_next;
    logic                         out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]       out_left_reg, out_left_next;
    logic [SAMPLE_BITS-1:0]       out_right_reg, out_right_next;

    logic                         accept;
    logic                         out_free;
    logic [WET_W-1:0]             wet;
    logic [WET_W-1:0]             dry;
    scq_pkg::scq_ctrl_t           ctrl_left;
    scq_pkg::scq_ctrl_t           ctrl_right;
    logic [ADDR_W-1:0]            wr_pos;
    logic [FILL_W-1:0]            fill;
    logic [SAMPLE_BITS-1:0]       left_result;
    logic [SAMPLE_BITS-1:0]       right_result;

    // Configuration registers.
    always_comb begin
        depth_left_next  = depth_left_reg;
        depth_right_next = depth_right_reg;
        lfo_period_next  = lfo_period_reg;
        lfo_step_next    = lfo_step_reg;
        wet_mix_next     = wet_mix_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                scq_pkg::REG_DEPTH_LEFT:  depth_left_next  = cfg_wdata[scq_pkg::DEPTH_W-1:0];
                scq_pkg::REG_DEPTH_RIGHT: depth_right_next = cfg_wdata[scq_pkg::DEPTH_W-1:0];
                scq_pkg::REG_LFO_PERIOD:  lfo_period_next  = cfg_wdata[scq_pkg::PERIOD_W-1:0];
                scq_pkg::REG_LFO_STEP:    lfo_step_next    = cfg_wdata[scq_pkg::STEP_W-1:0];
                scq_pkg::REG_WET_MIX:     wet_mix_next     = cfg_wdata[WET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_left_reg  <= scq_pkg::DEPTH_RST;
            depth_right_reg <= scq_pkg::DEPTH_RST;
            lfo_period_reg  <= scq_pkg::PERIOD_RST;
            lfo_step_reg    <= scq_pkg::STEP_RST;
            wet_mix_reg     <= scq_pkg::WET_RST;
            out_valid_reg   <= 1'b0;
        end else begin
            depth_left_reg  <= depth_left_next;
            depth_right_reg <= depth_right_next;
            lfo_period_reg  <= lfo_period_next;
            lfo_step_reg    <= lfo_step_next;
            wet_mix_reg     <= wet_mix_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // A wet share above unity is taken as unity.
    assign wet = (wet_mix_reg > scq_pkg::WET_ONE) ? scq_pkg::WET_ONE : wet_mix_reg;
    assign dry = scq_pkg::WET_ONE - wet;

    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    assign in_left_next  = accept ? s_left_sample : in_left_reg;
    assign in_right_next = accept ? s_right_sample : in_right_reg;

    // Merge stage: both lanes retire together into one output register.
    assign out_valid_next = ctrl_left.advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    assign out_left_next  = ctrl_left.advance ? left_result : out_left_reg;
    assign out_right_next = ctrl_left.advance ? right_result : out_right_reg;

    always_ff @(posedge aclk) begin
        in_left_reg   <= in_left_next;
        in_right_reg  <= in_right_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
    end

    scq_seq #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .out_free   (out_free),
        .lfo_period (lfo_period_reg),
        .lfo_step   (lfo_step_reg[scq_pkg::THETA_W-1:0]),
        .in_ready   (s_ready),
        .ctrl       (ctrl_left),
        .wr_pos     (wr_pos),
        .fill       (fill)
    );

    // The right lane runs a quarter LFO cycle ahead of the left.
    always_comb begin
        ctrl_right       = ctrl_left;
        ctrl_right.theta = ctrl_left.theta + scq_pkg::QUARTER_TURN;
    end

    scq_lane #(
        .DELAY_DEPTH  (DELAY_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_lane_left (
        .aclk   (aclk),
        .ctrl   (ctrl_left),
        .depth  (depth_left_reg),
        .wet    (wet),
        .dry    (dry),
        .sample (in_left_reg),
        .wr_pos (wr_pos),
        .fill   (fill),
        .result (left_result)
    );

    scq_lane #(
        .DELAY_DEPTH  (DELAY_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_lane_right (
        .aclk   (aclk),
        .ctrl   (ctrl_right),
        .depth  (depth_right_reg),
        .wet    (wet),
        .dry    (dry),
        .sample (in_right_reg),
        .wr_pos (wr_pos),
        .fill   (fill),
        .result (right_result)
    );

    assign m_valid     = out_valid_reg;
    assign m_left_out  = out_left_reg;
    assign m_right_out = out_right_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_left.advance |-> (!out_valid_reg || m_ready))
        else $error("result retired over an unread output");

    a_mix_unity: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_left.state == scq_pkg::ST_MIX)
            |-> ((17'(wet) + 17'(dry)) == 17'(scq_pkg::WET_ONE)))
        else $error("wet and dry shares do not sum to unity");

endmodule

// ===== verif/tb_stereo_quadrature_chorus_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo quadrature chorus testbench
// Drives stereo pairs through the valid/ready input channel in random bursts
// and stalls the result channel on its own pattern. A scoreboard class
// predicts each mixed pair from its own LFO, sine table and delay lines and
// compares every result in order. The run walks through several register
// settings, the extremes among them, written only while the block is idle.
// ----------------------------------------------------------------------------
module tb_stereo_quadrature_chorus_top;

    localparam int LINE_DEPTH = scq_pkg::DELAY_DEPTH_DEF;
    localparam int SMP_W      = scq_pkg::SAMPLE_BITS_DEF;
    localparam int SINE_N     = scq_pkg::SINE_ENTRIES_DEF;
    localparam longint MAX_DELAY   = longint'(LINE_DEPTH - 1) << 24;
    localparam longint SAMPLE_HIGH = (longint'(1) << (SMP_W - 1)) - 1;
    localparam longint SAMPLE_LOW  = -(longint'(1) << (SMP_W - 1));

    typedef struct packed {
        logic [SMP_W-1:0] left_out;
        logic [SMP_W-1:0] right_out;
    } stereo_pair_t;

    class chorus_scoreboard;
        int unsigned errors;
        logic [scq_pkg::DEPTH_W-1:0]  depth_l;
        logic [scq_pkg::DEPTH_W-1:0]  depth_r;
        logic [scq_pkg::PERIOD_W-1:0] period;
        logic [scq_pkg::STEP_W-1:0]   step;
        logic [scq_pkg::WET_W-1:0]    wet_mix;
        logic [scq_pkg::THETA_W-1:0]  phase;
        logic [10:0]                  wr_pos;
        logic signed [SMP_W-1:0]      line_l[LINE_DEPTH];
        logic signed [SMP_W-1:0]      line_r[LINE_DEPTH];
        int                           sine_lut[SINE_N];
        stereo_pair_t                 expected_pairs[$];

        function new();
            errors  = 0;
            depth_l = scq_pkg::DEPTH_RST;
            depth_r = scq_pkg::DEPTH_RST;
            period  = scq_pkg::PERIOD_RST;
            step    = scq_pkg::STEP_RST;
            wet_mix = scq_pkg::WET_RST;
            phase   = '0;
            wr_pos  = '0;
            foreach (line_l[i]) begin
                line_l[i] = '0;
                line_r[i] = '0;
            end
            foreach (sine_lut[k]) begin
                sine_lut[k] = sine_point(k);
            end
        endfunction

        // Quadrant folding, then an odd Taylor series in Q30 evaluated from
        // the innermost term outward, rounded half up to Q15.
        function int sine_point(int k);
            longint unsigned divs[5];
            longint unsigned p;
            longint unsigned r;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned t;
            longint unsigned s;
            longint unsigned q30;
            int unsigned quad;
            divs = '{110, 72, 42, 20, 6};
            q30 = 64'd1 << 30;
            p = k;
            p = (p << 32) / SINE_N;
            quad = int'((p >> 30) & 64'd3);
            r = p & (q30 - 1);
            if (quad[0]) begin
                r = q30 - r;
            end
            x  = (r * 64'd1686629713) >> 30;
            x2 = (x * x) >> 30;
            t  = q30;
            for (int i = 0; i < 5; i++) begin
                t = q30 - ((x2 * t) >> 30) / divs[i];
            end
            s = (x * t) >> 30;
            s = (s + 64'd16384) >> 15;
            if (s > 64'd32767) begin
                s = 64'd32767;
            end
            return (quad >= 2) ? -int'(s) : int'(s);
        endfunction

        function void report_mismatch(string what);
            errors++;
            if (errors <= 100) begin
                $display("[%0t] MISMATCH: %s", $time, what);
            end
        endfunction

        function void apply_config(logic [scq_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [scq_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                scq_pkg::REG_DEPTH_LEFT: depth_l = data[scq_pkg::DEPTH_W-1:0];
                scq_pkg::REG_DEPTH_RIGHT: depth_r = data[scq_pkg::DEPTH_W-1:0];
                scq_pkg::REG_LFO_PERIOD: period = data[scq_pkg::PERIOD_W-1:0];
                scq_pkg::REG_LFO_STEP: step = data[scq_pkg::STEP_W-1:0];
                scq_pkg::REG_WET_MIX: wet_mix = data[scq_pkg::WET_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [SMP_W-1:0] lane_mix(bit right_lane,
                                            logic [scq_pkg::DEPTH_W-1:0] depth,
                                            logic [scq_pkg::THETA_W-1:0] theta,
                                            logic signed [SMP_W-1:0] dry_in,
                                            longint wet, longint dry);
            longint lfo;
            longint dly;
            longint whole;
            longint frac;
            longint a;
            longint b;
            longint acc;
            longint delayed;
            longint mix;
            logic [10:0] tap_new;
            logic [10:0] tap_old;
            lfo = longint'(sine_lut[theta[23:14]]) + longint'(scq_pkg::LFO_MID);
            dly = longint'(depth) * lfo + (longint'(2) << 24);
            // Delays past the end of the line pin to the oldest entry.
            if (dly > MAX_DELAY) begin
                dly = MAX_DELAY;
            end
            whole = dly >>> 24;
            frac = dly & 64'hFFFFFF;
            tap_new = wr_pos - whole[10:0];
            tap_old = tap_new - 11'd1;
            if (right_lane) begin
                a = line_r[tap_new];
                b = line_r[tap_old];
            end else begin
                a = line_l[tap_new];
                b = line_l[tap_old];
            end
            // The older sample carries the fraction as its weight.
            acc = a * ((longint'(1) << 24) - frac) + b * frac;
            delayed = (acc + (longint'(1) << 23)) >>> 24;
            mix = (wet * delayed + dry * longint'(dry_in) + 16384) >>> 15;
            if (mix > SAMPLE_HIGH) begin
                mix = SAMPLE_HIGH;
            end
            if (mix < SAMPLE_LOW) begin
                mix = SAMPLE_LOW;
            end
            return mix[SMP_W-1:0];
        endfunction

        function void note_input(logic [SMP_W-1:0] l_in, logic [SMP_W-1:0] r_in);
            logic signed [SMP_W-1:0] xl;
            logic signed [SMP_W-1:0] xr;
            longint wet;
            longint dry;
            logic [63:0] prod;
            logic [scq_pkg::THETA_W-1:0] theta;
            logic [scq_pkg::THETA_W:0] next_phase;
            stereo_pair_t res;
            xl = l_in;
            xr = r_in;
            if (wet_mix > scq_pkg::WET_ONE) begin
                wet = longint'(scq_pkg::WET_ONE);
            end else begin
                wet = longint'(wet_mix);
            end
            dry = longint'(scq_pkg::WET_ONE) - wet;
            prod = phase;
            prod = prod * step;
            theta = prod[scq_pkg::THETA_W-1:0];
            res.left_out = lane_mix(1'b0, depth_l, theta, xl, wet, dry);
            res.right_out = lane_mix(1'b1, depth_r, theta + scq_pkg::QUARTER_TURN,
                                     xr, wet, dry);
            line_l[wr_pos] = xl;
            line_r[wr_pos] = xr;
            wr_pos = wr_pos + 11'd1;
            next_phase = {1'b0, phase} + 1'b1;
            if (next_phase > {1'b0, period}) begin
                next_phase = '0;
            end
            phase = next_phase[scq_pkg::THETA_W-1:0];
            expected_pairs.push_back(res);
        endfunction

        function void check_result(logic [SMP_W-1:0] l_got, logic [SMP_W-1:0] r_got);
            stereo_pair_t want;
            if (expected_pairs.size() == 0) begin
                report_mismatch($sformatf("result %h/%h with no pair pending",
                                          l_got, r_got));
                return;
            end
            want = expected_pairs.pop_front();
            if (l_got !== want.left_out) begin
                report_mismatch($sformatf("left_out got %h want %h",
                                          l_got, want.left_out));
            end
            if (r_got !== want.right_out) begin
                report_mismatch($sformatf("right_out got %h want %h",
                                          r_got, want.right_out));
            end
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [scq_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [scq_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [SMP_W-1:0] s_left_sample = '0;
    logic [SMP_W-1:0] s_right_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [SMP_W-1:0] m_left_out;
    logic [SMP_W-1:0] m_right_out;

    chorus_scoreboard sb;
    int stall_mode = 0;
    int stall_left = 0;

    stereo_quadrature_chorus_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_out     (m_left_out),
        .m_right_out    (m_right_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: runs of full throughput, random ready, and long stalls.
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(1, 40);
        end
        stall_left = stall_left - 1;
        case (stall_mode)
            0, 1: m_ready <= 1'b1;
            2: m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= 1'b0;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_left_out, m_right_out);
        end
    end

    function automatic logic [SMP_W-1:0] pick_sample();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(0, 9))
            0: begin
                case (raw[1:0])
                    2'd0: return 24'h7FFFFF;
                    2'd1: return 24'h800000;
                    2'd2: return 24'h000000;
                    default: return 24'hFFFFFF;
                endcase
            end
            1, 2: return 24'(int'($urandom_range(0, 8191)) - 4096);
            default: return raw[SMP_W-1:0];
        endcase
    endfunction

    task automatic send_pair(logic [SMP_W-1:0] l_smp, logic [SMP_W-1:0] r_smp);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_left_sample <= l_smp;
        s_right_sample <= r_smp;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sb.note_input(l_smp, r_smp);
    endtask

    task automatic hold_off(int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // Lets every pending request finish, then a margin past the pipeline.
    task automatic drain_and_settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_reg(logic [scq_pkg::CFG_INDEX_W-1:0] idx,
                             logic [scq_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.apply_config(idx, data);
    endtask

    task automatic write_config(logic [scq_pkg::CFG_DATA_W-1:0] dl,
                                logic [scq_pkg::CFG_DATA_W-1:0] dr,
                                logic [scq_pkg::CFG_DATA_W-1:0] per,
                                logic [scq_pkg::CFG_DATA_W-1:0] stp,
                                logic [scq_pkg::CFG_DATA_W-1:0] wet);
        write_reg(scq_pkg::REG_DEPTH_LEFT, dl);
        write_reg(scq_pkg::REG_DEPTH_RIGHT, dr);
        write_reg(scq_pkg::REG_LFO_PERIOD, per);
        write_reg(scq_pkg::REG_LFO_STEP, stp);
        write_reg(scq_pkg::REG_WET_MIX, wet);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(int count, bit pause_midway);
        int burst;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (pause_midway && i == count / 2) begin
                drain_and_settle();
            end else if (burst <= 0) begin
                burst = $urandom_range(1, 24);
                if ($urandom_range(0, 3) != 0) begin
                    hold_off($urandom_range(1, 14));
                end
            end
            burst--;
            send_pair(pick_sample(), pick_sample());
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings, back-to-back extremes.
        send_pair(24'h7FFFFF, 24'h800000);
        send_pair(24'h800000, 24'h7FFFFF);
        send_pair(24'h000000, 24'h000000);
        send_pair(24'hFFFFFF, 24'h000001);
        repeat (4) send_pair(24'h7FFFFF, 24'h7FFFFF);
        repeat (4) send_pair(24'h800000, 24'h800000);
        repeat (4) send_pair(24'h555555, 24'hAAAAAA);
        drain_and_settle();

        // Full wet; the right lane peaks past the end of its delay line.
        write_config(25'd0, 25'h7FFFF, 25'd15, 25'd1048576, 25'd32768);
        run_random(115, 1'b0);
        drain_and_settle();

        // Phase frozen at zero, oversized step, wet above unity.
        write_config(25'd522240, 25'd256, 25'd0, 25'h1FFFFFF, 25'hFFFF);
        run_random(115, 1'b0);
        drain_and_settle();

        // Dry only, LFO period register at one and step at zero.
        write_config(25'($urandom_range(0, 524287)), 25'($urandom_range(0, 524287)),
                     25'd1, 25'd0, 25'd0);
        run_random(115, 1'b0);
        drain_and_settle();

        write_config(25'($urandom_range(0, 524287)), 25'($urandom_range(0, 524287)),
                     25'($urandom_range(1, 300)), 25'($urandom() & 32'h1FFFFFF),
                     25'($urandom_range(0, 32768)));
        run_random(115, 1'b1);
        drain_and_settle();

        // Short delays so the taps land on freshly written samples.
        write_config(25'($urandom_range(0, 4096)), 25'($urandom_range(0, 4096)),
                     25'hFFFFFF, 25'($urandom() & 32'hFFFFFF),
                     25'($urandom() & 32'hFFFF));
        run_random(115, 1'b0);
        drain_and_settle();

        write_config(25'd2048, 25'd65536, 25'd63, 25'd266305, 25'd20000);
        run_random(115, 1'b0);
        drain_and_settle();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout waiting for the chorus to finish");
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/scq_pkg.sv
rtl/scq_ram.sv
rtl/scq_lane.sv
rtl/scq_seq.sv
rtl/stereo_quadrature_chorus_top.sv
verif/tb_stereo_quadrature_chorus_top.sv
